// ----- rtl/llq_pkg.sv -----
// Package with the sizes, status codes and sequencer states of the linked list queue manager.
`timescale 1ns / 1ps

package llq_pkg;

  // Pool size and the widths that follow from it.
  localparam int NODES   = 64;
  localparam int NODE_W  = 6;
  localparam int COUNT_W = $clog2(NODES + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LINKED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_APP_SELF,
    S_APP_READ,
    S_APP_LINK,
    S_APP_HEAD,
    S_REM_ONE,
    S_REM_READ,
    S_REM_LINK
  } state_t;

  // Result cycle: the sequencer is back at rest and the result is shown.
  localparam state_t S_DONE = S_IDLE;

endpackage

// ----- rtl/llq_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read through a registered output.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/linked_list_queue_manager.sv -----
// Top level of the circular doubly linked queue manager over a pool of indexed nodes.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. mode 0 appends node at the
// tail of the queue, mode 1 removes node from it. Each word gives exactly one result
// word, shown for one cycle with done high; the receiver cannot stall it. A rejected
// word shows done in the cycle after the accepting edge. An append to an empty queue
// steps through S_APP_SELF, a removal of the last node through S_REM_ONE, a remove of
// one of several nodes through S_REM_READ and S_REM_LINK, and an append to a non-empty
// queue through S_APP_READ, S_APP_LINK and S_APP_HEAD before done shows. Busy drops in
// the cycle that shows done, so a new word can be accepted then and not while one is
// under way. Appends take these steps as each pointer memory has one write port and a
// registered read, and an append writes the prev memory twice after reading the old
// tail. Linked flags are flip-flops cleared by reset, so reset leaves the block ready.
module linked_list_queue_manager (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [llq_pkg::NODE_W-1:0]  node,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [llq_pkg::COUNT_W-1:0] count,
  output logic [llq_pkg::NODE_W-1:0]  head_node,
  output logic                        head_valid
);

  import llq_pkg::*;

  state_t               state, state_next;
  status_t              result, accept_status;
  logic                 done_flag;
  logic [NODE_W-1:0]    op_node;
  logic [NODE_W-1:0]    head_index;
  logic [COUNT_W-1:0]   node_count;
  logic [NODES-1:0]     linked_flag;
  logic                 accept;
  logic                 in_range;
  logic                 node_linked;

  // Pointer memory ports.
  logic                 next_we, prev_we;
  logic [NODE_W-1:0]    next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [NODE_W-1:0]    next_raddr, prev_raddr;
  logic [NODE_W-1:0]    next_rdata, prev_rdata;

  llq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  llq_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // Checks on the incoming word, made against the pool size and the linked flags.
  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign in_range    = (COUNT_W'(node) < COUNT_W'(NODES));
  assign node_linked = in_range && linked_flag[node];

  // Next state, with the decision on a newly accepted word.
  always_comb begin
    state_next    = state;
    accept_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!mode) begin
            if (!in_range) begin
              accept_status = ST_ABSENT;
              state_next    = S_DONE;
            end else if (node_linked) begin
              accept_status = ST_LINKED;
              state_next    = S_DONE;
            end else if (node_count == '0) begin
              state_next = S_APP_SELF;
            end else begin
              state_next = S_APP_READ;
            end
          end else begin
            if (node_count == '0) begin
              accept_status = ST_EMPTY;
              state_next    = S_DONE;
            end else if (!node_linked) begin
              accept_status = ST_ABSENT;
              state_next    = S_DONE;
            end else if (node_count == COUNT_W'(1)) begin
              state_next = S_REM_ONE;
            end else begin
              state_next = S_REM_READ;
            end
          end
        end
      end
      S_APP_SELF: state_next = S_DONE;
      S_APP_READ: state_next = S_APP_LINK;
      S_APP_LINK: state_next = S_APP_HEAD;
      S_APP_HEAD: state_next = S_DONE;
      S_REM_ONE:  state_next = S_DONE;
      S_REM_READ: state_next = S_REM_LINK;
      S_REM_LINK: state_next = S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Pointer memory accesses for each step.
  always_comb begin
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = op_node;
    next_wdata = op_node;
    prev_waddr = op_node;
    prev_wdata = op_node;
    next_raddr = op_node;
    prev_raddr = op_node;
    unique case (state)
      S_APP_SELF: begin
        // A lone node points at itself both ways.
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      S_APP_READ: begin
        // Fetch the tail and point the new node forward at the head.
        prev_raddr = head_index;
        next_we    = 1'b1;
        next_wdata = head_index;
      end
      S_APP_LINK: begin
        // Splice the new node after the old tail.
        next_we    = 1'b1;
        next_waddr = prev_rdata;
        prev_we    = 1'b1;
        prev_wdata = prev_rdata;
      end
      S_APP_HEAD: begin
        prev_we    = 1'b1;
        prev_waddr = head_index;
      end
      S_REM_LINK: begin
        // Join the neighbors of the removed node.
        next_we    = 1'b1;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        prev_we    = 1'b1;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, queue bookkeeping and the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done_flag   <= 1'b0;
      result      <= ST_OK;
      head_index  <= '0;
      node_count  <= '0;
      linked_flag <= '0;
    end else begin
      state     <= state_next;
      done_flag <= 1'b0;
      if (accept) begin
        op_node <= node;
        result  <= accept_status;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && state_next == S_DONE) begin
            done_flag <= 1'b1;
          end
        end
        S_APP_SELF: begin
          head_index           <= op_node;
          node_count           <= node_count + COUNT_W'(1);
          linked_flag[op_node] <= 1'b1;
          done_flag            <= 1'b1;
        end
        S_APP_HEAD: begin
          node_count           <= node_count + COUNT_W'(1);
          linked_flag[op_node] <= 1'b1;
          done_flag            <= 1'b1;
        end
        S_REM_ONE: begin
          node_count           <= '0;
          linked_flag[op_node] <= 1'b0;
          done_flag            <= 1'b1;
        end
        S_REM_LINK: begin
          if (head_index == op_node) begin
            head_index <= next_rdata;
          end
          node_count           <= node_count - COUNT_W'(1);
          linked_flag[op_node] <= 1'b0;
          done_flag            <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result ports.
  always_comb begin
    done       = done_flag;
    status     = result;
    count      = node_count;
    head_valid = (node_count != '0);
    head_node  = head_valid ? head_index : '0;
  end

endmodule

// ----- rtl/llq_checker.sv -----
// Port level checks of the linked list queue manager and their binding to the top level.
`timescale 1ns / 1ps

module llq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        mode,
  input logic [llq_pkg::NODE_W-1:0]  node,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [llq_pkg::COUNT_W-1:0] count,
  input logic [llq_pkg::NODE_W-1:0]  head_node,
  input logic                        head_valid
);

  import llq_pkg::*;

  // An accepted word keeps the block busy or shows its result word in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted word did not occupy the block");

  // A result word follows a cycle in which a word was accepted or under way.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result word without a word in progress");

  // The head is reported exactly when the queue holds nodes, and reads zero otherwise.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (head_valid == (count != '0)) && (head_valid || head_node == '0))
    else $error("head report disagrees with the count");

  // The count never exceeds the pool, and an empty queue report comes with count zero.
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> count <= COUNT_W'(NODES) && (status != ST_EMPTY || count == '0))
    else $error("count out of range for the reported status");

endmodule

bind linked_list_queue_manager llq_checker u_llq_checker (.*);
